### design/tsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_pkg
// Shared types and constants of the periodic soft timer bank.
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int BEAT_W  = 10;
  localparam int OP_W    = 2;
  localparam int ID_W    = 16;
  localparam int TAG_W   = 32;
  localparam int IVL_W   = 24;
  localparam int TIME_W  = 32;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [BEAT_W-1:0] BEAT_RESET = BEAT_W'(10);

  // register select bit of paddr (byte address 4*i)
  localparam logic REG_BEAT = 1'b0;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRE   = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_FIND,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [ID_W-1:0]  timer_id;
    logic [TAG_W-1:0] owner_tag;
    logic [IVL_W-1:0] interval_ms;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic              ok;
    logic [ID_W-1:0]   fired_id;
    logic [TAG_W-1:0]  fired_tag;
    logic [TIME_W-1:0] time_ms;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [IVL_W-1:0] count;
    logic [IVL_W-1:0] period;
    logic [ID_W-1:0]  ident;
    logic [TAG_W-1:0] owner;
  } slot_t;

  typedef struct packed {
    logic                  set_count;
    logic                  arm;
    logic                  free;
    logic [SLOT_IDX_W-1:0] idx;
    logic [IVL_W-1:0]      count;
    logic [IVL_W-1:0]      period;
    logic [ID_W-1:0]       ident;
    logic [TAG_W-1:0]      owner;
  } slot_wr_t;

endpackage

### design/tsb_slot_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_slot_bank
// Timer slot storage: one read port and one write port, indexed by the walk.
// ----------------------------------------------------------------------------
module tsb_slot_bank (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [tsb_pkg::SLOT_IDX_W-1:0] rd_idx_i,
  output tsb_pkg::slot_t                 rd_slot_o,
  input  tsb_pkg::slot_wr_t              wr_i
);
  import tsb_pkg::*;

  logic [NUM_SLOTS-1:0] valid_q;
  logic [IVL_W-1:0]     count_q  [NUM_SLOTS];
  logic [IVL_W-1:0]     period_q [NUM_SLOTS];
  logic [ID_W-1:0]      ident_q  [NUM_SLOTS];
  logic [TAG_W-1:0]     owner_q  [NUM_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.arm) begin
      valid_q[wr_i.idx] <= 1'b1;
    end else if (wr_i.free) begin
      valid_q[wr_i.idx] <= 1'b0;
    end
  end

  // payload is only looked at behind its valid bit
  always_ff @(posedge clk_i) begin
    if (wr_i.arm) begin
      count_q[wr_i.idx]  <= wr_i.count;
      period_q[wr_i.idx] <= wr_i.period;
      ident_q[wr_i.idx]  <= wr_i.ident;
      owner_q[wr_i.idx]  <= wr_i.owner;
    end else if (wr_i.set_count) begin
      count_q[wr_i.idx] <= wr_i.count;
    end
  end

  assign rd_slot_o = '{valid:  valid_q[rd_idx_i],
                       count:  count_q[rd_idx_i],
                       period: period_q[rd_idx_i],
                       ident:  ident_q[rd_idx_i],
                       owner:  owner_q[rd_idx_i]};

endmodule

### design/tsb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_ctrl
// Walks the slots one per cycle, held by out stalls; shared add/compare unit.
// ----------------------------------------------------------------------------
module tsb_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  tsb_pkg::in_item_t              in_item_i,
  output logic                           in_stall_o,
  input  logic [tsb_pkg::BEAT_W-1:0]     beat_i,
  input  logic                           out_ready_i,
  output logic                           res_load_o,
  output tsb_pkg::out_item_t             res_o,
  output logic [tsb_pkg::SLOT_IDX_W-1:0] slot_idx_o,
  input  tsb_pkg::slot_t                 slot_i,
  output tsb_pkg::slot_wr_t              slot_wr_o
);
  import tsb_pkg::*;

  state_e                state_q, state_d;
  logic [SLOT_IDX_W-1:0] idx_q, idx_d;
  logic [OP_W-1:0]       op_q, op_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic [TAG_W-1:0]      tag_q, tag_d;
  logic [IVL_W-1:0]      ivl_q, ivl_d;
  logic [TIME_W-1:0]     clock_q, clock_d;
  logic [NUM_SLOTS-1:0]  mask_q, mask_d;
  logic                  match_found_q, match_found_d;
  logic [SLOT_IDX_W-1:0] match_idx_q, match_idx_d;
  logic                  free_found_q, free_found_d;
  logic [SLOT_IDX_W-1:0] free_idx_q, free_idx_d;

  // shared unit: widened add and compare
  logic [IVL_W:0] sum;
  logic           hit_fire;
  logic           last_idx;
  logic           id_match;

  assign sum      = {1'b0, slot_i.count} + (IVL_W + 1)'(beat_i);
  assign hit_fire = sum >= {1'b0, slot_i.period};
  assign last_idx = idx_q == SLOT_IDX_W'(NUM_SLOTS - 1);
  assign id_match = slot_i.valid && (slot_i.ident == id_q) && (slot_i.owner == tag_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      idx_q         <= '0;
      clock_q       <= '0;
      mask_q        <= '0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      clock_q       <= clock_d;
      mask_q        <= mask_d;
      match_found_q <= match_found_d;
      free_found_q  <= free_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    id_q        <= id_d;
    tag_q       <= tag_d;
    ivl_q       <= ivl_d;
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    op_d          = op_q;
    id_d          = id_q;
    tag_d         = tag_q;
    ivl_d         = ivl_q;
    clock_d       = clock_q;
    mask_d        = mask_q;
    match_found_d = match_found_q;
    match_idx_d   = match_idx_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    in_stall_o    = 1'b1;
    res_load_o    = 1'b0;
    res_o         = '0;
    slot_idx_o    = idx_q;
    slot_wr_o     = '0;
    slot_wr_o.idx = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_d          = in_item_i.opcode;
          id_d          = in_item_i.timer_id;
          tag_d         = in_item_i.owner_tag;
          ivl_d         = in_item_i.interval_ms;
          idx_d         = '0;
          mask_d        = '0;
          match_found_d = 1'b0;
          free_found_d  = 1'b0;
          unique case (in_item_i.opcode) inside
            OP_TICK: begin
              clock_d = clock_q + TIME_W'(beat_i);
              state_d = ST_SCAN;
            end
            OP_ADD, OP_REMOVE: begin
              state_d = ST_FIND;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (slot_i.valid) begin
          slot_wr_o.set_count = 1'b1;
          if (hit_fire) begin
            slot_wr_o.count = '0;
            mask_d[idx_q]   = 1'b1;
          end else begin
            slot_wr_o.count = sum[IVL_W-1:0];
          end
        end
        if (last_idx) begin
          idx_d   = '0;
          state_d = (mask_d != '0) ? ST_EMIT : ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_EMIT: begin
        if (!mask_q[idx_q]) begin
          idx_d = idx_q + 1'b1;
        end else if (out_ready_i) begin
          mask_d[idx_q]   = 1'b0;
          res_load_o      = 1'b1;
          res_o.kind      = KIND_FIRE;
          res_o.fired_id  = slot_i.ident;
          res_o.fired_tag = slot_i.owner;
          res_o.time_ms   = clock_q;
          res_o.last      = mask_d == '0;
          if (mask_d == '0) begin
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      ST_FIND: begin
        if (id_match && !match_found_q) begin
          match_found_d = 1'b1;
          match_idx_d   = idx_q;
        end
        if (!slot_i.valid && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = idx_q;
        end
        if (last_idx) begin
          idx_d   = '0;
          state_d = ST_COMMIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_COMMIT: begin
        if (out_ready_i) begin
          res_load_o    = 1'b1;
          res_o.kind    = KIND_STATUS;
          res_o.time_ms = clock_q;
          res_o.last    = 1'b1;
          if (op_q == OP_ADD) begin
            if (match_found_q || free_found_q) begin
              slot_wr_o.arm    = 1'b1;
              slot_wr_o.idx    = match_found_q ? match_idx_q : free_idx_q;
              slot_wr_o.count  = '0;
              slot_wr_o.period = ivl_q;
              slot_wr_o.ident  = id_q;
              slot_wr_o.owner  = tag_q;
              res_o.ok         = 1'b1;
            end
          end else if (match_found_q) begin
            slot_wr_o.free = 1'b1;
            slot_wr_o.idx  = match_idx_q;
            res_o.ok       = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // emit walk only runs while some fire is still owed
  a_emit_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> mask_q != '0)
    else $error("emit walk with no pending fire");

  // a status item is always the only and final item of its input
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o && res_o.kind == KIND_STATUS |-> res_o.last)
    else $error("status item without last");

  // an accepted add starts the slot search
  a_add_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.opcode == OP_ADD |=> state_q == ST_FIND)
    else $error("add did not start slot search");

endmodule

### design/periodic_soft_timer_bank_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_soft_timer_bank_unit
// Bank of periodic timers: tick, add and remove items walk the slot bank.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        input      in_valid_i/in_stall_o   in_item_i  (tsb_pkg::in_item_t)
//  out       output     out_valid_o/out_stall_i out_item_o (tsb_pkg::out_item_t)
//  config    input      apb psel/penable/pready beat_ms at byte address 0
//
//  a tick walks every slot to update the counters, then walks the slots up
//  to the highest firing one to hand out fire items, one slot per cycle while
//  the output takes them; an add or remove searches every slot, then commits
//  the walks are set by the single slot read port walked one slot a cycle
//  out stalls hold the sequencer only when the output register is still full
//  reset clears all slots, the clock and beat_ms back to 10
// ----------------------------------------------------------------------------
module periodic_soft_timer_bank_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tsb_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tsb_pkg::out_item_t          out_item_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsb_pkg::PADDR_W-1:0] paddr,
  input  logic [tsb_pkg::PDATA_W-1:0] pwdata,
  output logic [tsb_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import tsb_pkg::*;

  // config register
  logic [BEAT_W-1:0] beat_q;
  logic              reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready && (paddr[PADDR_W-1] == REG_BEAT);
  assign prdata = (paddr[PADDR_W-1] == REG_BEAT) ? PDATA_W'(beat_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= BEAT_RESET;
    end else if (reg_wr) begin
      beat_q <= pwdata[BEAT_W-1:0];
    end
  end

  // slot bank and sequencer
  logic [SLOT_IDX_W-1:0] slot_idx;
  slot_t                 slot_rd;
  slot_wr_t              slot_wr;
  logic                  out_ready;
  logic                  res_load;
  out_item_t             res;

  tsb_slot_bank u_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (slot_idx),
    .rd_slot_o (slot_rd),
    .wr_i      (slot_wr)
  );

  tsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .beat_i      (beat_q),
    .out_ready_i (out_ready),
    .res_load_o  (res_load),
    .res_o       (res),
    .slot_idx_o  (slot_idx),
    .slot_i      (slot_rd),
    .slot_wr_o   (slot_wr)
  );

  // output register: takes a new item when empty or being drained
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  assign out_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // sequencer never overwrites a held, stalled item
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !(out_valid_q && out_stall_i))
    else $error("output item overwritten while stalled");

  // a real operation keeps the block busy in the next cycle
  a_busy_after_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_item_i.opcode == OP_TICK || in_item_i.opcode == OP_ADD ||
     in_item_i.opcode == OP_REMOVE) |=> in_stall_o)
    else $error("block ready right after accepting an operation");

endmodule

### dv/tsb_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_result_checker
// Tracks the timer bank from the items it accepts and from the beat register
// writes, and compares every out item, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module tsb_result_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  tsb_pkg::in_item_t           in_item_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  tsb_pkg::out_item_t          out_item_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [tsb_pkg::PADDR_W-1:0] paddr_i,
  input  logic [tsb_pkg::PDATA_W-1:0] pwdata_i,
  input  logic [tsb_pkg::PDATA_W-1:0] prdata_i,
  output int                          mismatch_cnt_o,
  output int                          pending_cnt_o,
  output int                          fire_cnt_o,
  output int                          status_cnt_o
);
  import tsb_pkg::*;

  typedef struct {
    logic             armed;
    logic [IVL_W-1:0] elapsed;
    logic [IVL_W-1:0] period;
    logic [ID_W-1:0]  ident;
    logic [TAG_W-1:0] owner;
  } timer_slot_t;

  timer_slot_t       bank [NUM_SLOTS];
  logic [BEAT_W-1:0] beat_ms;
  logic [TIME_W-1:0] now_ms;
  out_item_t         due_q [$];
  int                mismatches;
  int                fires;
  int                statuses;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic int find_timer(input logic [ID_W-1:0] id,
                                    input logic [TAG_W-1:0] tag);
    for (int i = 0; i < NUM_SLOTS; i++)
      if (bank[i].armed && bank[i].ident == id && bank[i].owner == tag)
        return i;
    return -1;
  endfunction

  function automatic int find_idle_slot();
    for (int i = 0; i < NUM_SLOTS; i++)
      if (!bank[i].armed)
        return i;
    return -1;
  endfunction

  // applies one accepted item to the bank and queues the items it causes
  task automatic advance_bank(input in_item_t it);
    out_item_t      res;
    logic [IVL_W:0] sum;
    int             s;
    int             n;
    n = 0;
    case (it.opcode)
      OP_TICK: begin
        now_ms = now_ms + TIME_W'(beat_ms);
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (bank[i].armed) begin
            // one bit wider so the sum never wraps before the compare
            sum = {1'b0, bank[i].elapsed} + (IVL_W + 1)'(beat_ms);
            if (sum >= {1'b0, bank[i].period}) begin
              bank[i].elapsed = '0;
              res = '0;
              res.kind = KIND_FIRE;
              res.fired_id = bank[i].ident;
              res.fired_tag = bank[i].owner;
              res.time_ms = now_ms;
              due_q.push_back(res);
              n++;
            end else begin
              bank[i].elapsed = sum[IVL_W-1:0];
            end
          end
        end
      end
      OP_ADD: begin
        s = find_timer(it.timer_id, it.owner_tag);
        if (s < 0)
          s = find_idle_slot();
        res = '0;
        res.kind = KIND_STATUS;
        res.time_ms = now_ms;
        if (s >= 0) begin
          bank[s].armed = 1'b1;
          bank[s].elapsed = '0;
          bank[s].period = it.interval_ms;
          bank[s].ident = it.timer_id;
          bank[s].owner = it.owner_tag;
          res.ok = 1'b1;
        end
        due_q.push_back(res);
        n = 1;
      end
      OP_REMOVE: begin
        s = find_timer(it.timer_id, it.owner_tag);
        res = '0;
        res.kind = KIND_STATUS;
        res.time_ms = now_ms;
        if (s >= 0) begin
          bank[s].armed = 1'b0;
          res.ok = 1'b1;
        end
        due_q.push_back(res);
        n = 1;
      end
      default: ;
    endcase
    if (n > 0) begin
      res = due_q.pop_back();
      res.last = 1'b1;
      due_q.push_back(res);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (got.kind === KIND_FIRE)
      fires++;
    else
      statuses++;
    if (due_q.size() == 0) begin
      report($sformatf("unexpected item kind %0b ok %0b id %h tag %h time %0d",
                       got.kind, got.ok, got.fired_id, got.fired_tag, got.time_ms));
      return;
    end
    want = due_q.pop_front();
    check_field("kind", 64'(got.kind), 64'(want.kind));
    check_field("ok", 64'(got.ok), 64'(want.ok));
    check_field("fired_id", 64'(got.fired_id), 64'(want.fired_id));
    check_field("fired_tag", 64'(got.fired_tag), 64'(want.fired_tag));
    check_field("time_ms", 64'(got.time_ms), 64'(want.time_ms));
    check_field("last", 64'(got.last), 64'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        bank[i].armed = 1'b0;
        bank[i].elapsed = '0;
        bank[i].period = '0;
        bank[i].ident = '0;
        bank[i].owner = '0;
      end
      beat_ms = BEAT_RESET;
      now_ms = '0;
      due_q.delete();
    end else begin
      // results leave before the item accepted at the same edge is applied
      if (out_valid_i && !out_stall_i)
        check_result(out_item_i);
      if (in_valid_i && !in_stall_i)
        advance_bank(in_item_i);
      if (psel_i && penable_i && pready_i && paddr_i[PADDR_W-1] == REG_BEAT) begin
        if (pwrite_i)
          beat_ms = pwdata_i[BEAT_W-1:0];
        else if (prdata_i !== PDATA_W'(beat_ms))
          report($sformatf("beat_ms read %0h expected %0h", prdata_i, beat_ms));
      end
    end
    mismatch_cnt_o <= mismatches;
    pending_cnt_o <= due_q.size();
    fire_cnt_o <= fires;
    status_cnt_o <= statuses;
  end

endmodule

### dv/tb_periodic_soft_timer_bank_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_soft_timer_bank_unit
// Drives tick, add and remove items into the timer bank under several beat
// settings, with random gaps on the in channel and random out stalls; the
// checker beside the block predicts and compares every out item.
// ----------------------------------------------------------------------------
module tb_periodic_soft_timer_bank_unit;
  import tsb_pkg::*;

  // opcode value the block has to ignore
  localparam logic [OP_W-1:0]    OP_UNUSED = 2'd3;
  // byte address of beat_ms
  localparam logic [PADDR_W-1:0] BEAT_ADDR = {REG_BEAT, 2'b00};

  // longest wait for a tick to finish once nothing more is due: walk of the
  // slots plus the emit walk, with margin
  localparam int DRAIN_CYCLES   = 40;
  // cycles with no accepted item before the run is declared hung
  localparam int WATCHDOG_LIMIT = 3000;
  // counted items per random phase
  localparam int PHASE_OPS      = 48;
  localparam int NUM_PHASES     = 6;

  // identities that adds and removes draw from, extremes among them, so that
  // removes find their timers and the bank fills and drains again
  localparam logic [ID_W-1:0]  ID_POOL  [6] = '{16'h0000, 16'h0001, 16'h0002,
                                                16'hFFFF, 16'h8000, 16'h5A5A};
  localparam logic [TAG_W-1:0] TAG_POOL [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                32'h5A5A_0F0F, 32'hA5A5_F0F0};

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_item_t           in_item_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_item_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fails;
  int pending;
  int fires;
  int statuses;

  // stimulus bookkeeping
  int  cur_beat   = BEAT_RESET;
  bit  calm       = 1'b0;
  int  ticks      = 0;
  int  adds       = 0;
  int  removes    = 0;
  int  ignored    = 0;
  int  beat_sets  = 0;
  int  quiet_cycles = 0;

  periodic_soft_timer_bank_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  tsb_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .in_item_i      (in_item_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_item_i     (out_item_o),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .mismatch_cnt_o (fails),
    .pending_cnt_o  (pending),
    .fire_cnt_o     (fires),
    .status_cnt_o   (statuses)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver side: random stalls on about a fifth of the cycles, none while
  // calm so the block also sees a long run at full rate
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 22);
  end

  // hang detection: any accepted item or config access restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results still due",
               quiet_cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t timer_op(input logic [OP_W-1:0] op,
                                        input logic [ID_W-1:0] id,
                                        input logic [TAG_W-1:0] tag,
                                        input logic [IVL_W-1:0] ivl);
    in_item_t it;
    it.opcode = op;
    it.timer_id = id;
    it.owner_tag = tag;
    it.interval_ms = ivl;
    return it;
  endfunction

  // one random item: ticks carry fully random fields since the block ignores
  // them, adds and removes work on the identity pool
  function automatic in_item_t random_op();
    in_item_t it;
    int       pick;
    pick = $urandom_range(99);
    it.timer_id = ID_POOL[$urandom_range(5)];
    it.owner_tag = TAG_POOL[$urandom_range(3)];
    // mostly periods near the beat so timers fire, now and then a huge one
    if ($urandom_range(7) == 0)
      it.interval_ms = IVL_W'($urandom);
    else
      it.interval_ms = IVL_W'($urandom_range(4 * cur_beat + 3));
    if (pick < 38) begin
      it = timer_op(OP_TICK, ID_W'($urandom), $urandom, IVL_W'($urandom));
    end else if (pick < 70) begin
      it.opcode = OP_ADD;
    end else if (pick < 95) begin
      it.opcode = OP_REMOVE;
      // a stranger identity is simply not found
      if ($urandom_range(5) == 0) begin
        it.timer_id = ID_W'($urandom);
        it.owner_tag = $urandom;
      end
    end else begin
      it = timer_op(OP_UNUSED, ID_W'($urandom), $urandom, IVL_W'($urandom));
    end
    return it;
  endfunction

  // presents one item and returns at the edge that accepts it; valid stays
  // high so a following item goes out back to back
  task automatic send_op(input in_item_t it);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 22)
      gap = $urandom_range(1, 24);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    case (it.opcode)
      OP_TICK:   ticks++;
      OP_ADD:    adds++;
      OP_REMOVE: removes++;
      default:   ignored++;
    endcase
  endtask

  // waits until every due item is out and the block has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // a tick that fires nothing leaves no trace in the due count
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // apb write of beat_ms, then a read back in the very next transfer
  task automatic set_beat(input int beat);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= BEAT_ADDR;
    // upper bits of the write data carry noise that the register drops
    pwdata <= {(PDATA_W - BEAT_W)'($urandom), BEAT_W'(beat)};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    cur_beat = beat & ((1 << BEAT_W) - 1);
    beat_sets++;
  endtask

  initial begin
    int done;
    int phase_beat [NUM_PHASES];
    in_item_t it;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, beat at its reset value of 10
    // tick on an empty bank gives no item at all
    send_op(timer_op(OP_TICK, '0, '0, '0));
    // remove of a timer that does not exist
    send_op(timer_op(OP_REMOVE, 16'd3, 32'd3, '0));
    // unused opcode, all ones everywhere
    send_op(timer_op(OP_UNUSED, '1, '1, '1));
    // zero period fires on every tick, the largest period never here
    send_op(timer_op(OP_ADD, '0, '0, '0));
    send_op(timer_op(OP_ADD, '1, '1, '1));
    send_op(timer_op(OP_ADD, 16'd1, 32'd5, 24'd30));
    // third tick brings the 30 ms timer due
    repeat (3) send_op(timer_op(OP_TICK, '0, '0, '0));
    // re-arm by matching id and tag, then same id with another tag
    send_op(timer_op(OP_ADD, 16'd1, 32'd5, 24'd20));
    send_op(timer_op(OP_ADD, 16'd1, 32'd6, 24'd10));
    for (int k = 2; k < 6; k++)
      send_op(timer_op(OP_ADD, ID_W'(k), 32'hA5A5_A5A5, 24'd10));
    // every slot taken now, so this add is refused
    send_op(timer_op(OP_ADD, 16'd6, '0, 24'd10));
    send_op(timer_op(OP_TICK, '0, '0, '0));
    // remove found, then the same remove not found
    send_op(timer_op(OP_REMOVE, '1, '1, '0));
    send_op(timer_op(OP_REMOVE, '1, '1, '0));
    send_op(timer_op(OP_ADD, 16'd7, 32'd7, 24'd1));
    send_op(timer_op(OP_ADD, 16'd1, 32'd5, 24'd10));
    // all eight timers due on one tick
    send_op(timer_op(OP_TICK, '0, '0, '0));
    settle();

    // zero beat: clock and counters stand still, zero periods still fire
    set_beat(0);
    send_op(timer_op(OP_TICK, '0, '0, '0));
    settle();
    // largest beat the register holds
    set_beat((1 << BEAT_W) - 1);
    send_op(timer_op(OP_TICK, '0, '0, '0));
    send_op(timer_op(OP_TICK, '0, '0, '0));
    settle();

    // random phases, each under its own beat
    phase_beat = '{1, 1000, 0, (1 << BEAT_W) - 1, $urandom_range(1, 1000), BEAT_RESET};
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_beat(phase_beat[p]);
      // one phase runs with no gaps and no stalls at all
      calm = (p == 1);
      done = 0;
      while (done < PHASE_OPS) begin
        it = random_op();
        send_op(it);
        if (it.opcode != OP_UNUSED)
          done++;
      end
      settle();
    end
    calm = 1'b0;

    $display("run: %0d ticks, %0d adds, %0d removes, %0d ignored items over %0d beat writes",
             ticks, adds, removes, ignored, beat_sets);
    $display("run: %0d fire items and %0d status items compared", fires, statuses);
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
